// ===== rtl/rpa_pkg.sv =====
// Shared opcodes, status codes and controller/datapath handshake types.
package rpa_pkg;

  localparam logic [2:0] OP_ADD_USABLE = 3'd0;
  localparam logic [2:0] OP_RESERVE    = 3'd1;
  localparam logic [2:0] OP_ALLOC      = 3'd2;
  localparam logic [2:0] OP_FREE       = 3'd3;
  localparam logic [2:0] OP_REF        = 3'd4;
  localparam logic [2:0] OP_UNREF      = 3'd5;
  localparam logic [2:0] OP_GETREF     = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_MEM   = 3'd1;
  localparam logic [2:0] ST_BOUNDS   = 3'd2;
  localparam logic [2:0] ST_REF_FREE = 3'd3;
  localparam logic [2:0] ST_UNDER    = 3'd4;
  localparam logic [2:0] ST_ZERO     = 3'd5;

  localparam logic [12:0] LIMIT_RESET = 13'd4096;

  typedef struct packed {
    logic clear;   // clearing pass: write one page to used/count 1
    logic start;   // latch a new item
    logic rd;      // read page at pointer
    logic apply;   // update page from read data
    logic take;    // mark page used for an allocated run
    logic finish;  // load result register
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic fail;
    logic done;
    logic hit;
    logic take_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/rpa_req_if.sv =====
// Request channel: operation item with valid/ready.
interface rpa_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [11:0] first_page;
  logic [12:0] page_count;
  modport source (output valid, opcode, first_page, page_count, input ready);
  modport sink   (input valid, opcode, first_page, page_count, output ready);
endinterface

// ===== rtl/rpa_rsp_if.sv =====
// Response channel: result item with valid/ready.
interface rpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] alloc_page;
  logic [15:0] ref_value;
  logic [12:0] free_total;
  logic [12:0] usable_total;
  modport source (output valid, status, alloc_page, ref_value, free_total, usable_total,
                  input ready);
  modport sink   (input valid, status, alloc_page, ref_value, free_total, usable_total,
                  output ready);
endinterface

// ===== rtl/rpa_ctrl.sv =====
// Sequencer for the page allocator: clearing pass, page loops, result hand-off.
module rpa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  rpa_pkg::dp_sts_t sts_i,
  output rpa_pkg::dp_cmd_t cmd_o
);
  import rpa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_TAKE  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.fail || sts_i.done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = sts_i.hit ? S_TAKE : S_READ;
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        if (sts_i.take_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rpa_datapath.sv =====
// Page map memory, pointers, counters and result register.
module rpa_datapath #(
  parameter int N_PAGES  = 4096,
  parameter int REF_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [12:0]      cfg_wdata_i,
  input  logic [2:0]       opcode_i,
  input  logic [11:0]      first_page_i,
  input  logic [12:0]      page_count_i,
  input  rpa_pkg::dp_cmd_t cmd_i,
  output rpa_pkg::dp_sts_t sts_o,
  input  logic             rsp_ready_i,
  output logic             rsp_valid_o,
  output logic [2:0]       status_o,
  output logic [11:0]      alloc_page_o,
  output logic [15:0]      ref_value_o,
  output logic [12:0]      free_total_o,
  output logic [12:0]      usable_total_o
);
  import rpa_pkg::*;

  localparam int AW = $clog2(N_PAGES);
  localparam int LW = $clog2(N_PAGES + 1);
  localparam int CW = (LW > 13) ? LW : 13;
  localparam int PW = CW + 1;
  localparam int MW = REF_BITS + 1;

  logic [MW-1:0]       mem [N_PAGES];
  logic [MW-1:0]       rdata_q;
  logic                mem_we;
  logic [MW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_addr;

  logic [12:0]         limit_q;
  logic [PW-1:0]       ptr_q, ptr_d;
  logic [PW-1:0]       end_q, cnt_q, run_q, run_d, rs_q, rs_d;
  logic [2:0]          op_q;
  logic [2:0]          st_q, st_d;
  logic [REF_BITS-1:0] refv_q, refv_d;
  logic                found_q, found_d, visited_q, fail_q, fail_d;
  logic [2:0]          fail_st_q, fail_st_d;
  logic [LW-1:0]       free_q, free_d, usable_q, usable_d;
  logic                free_inc, free_dec, usable_inc;
  logic                loop_done;

  logic [PW-1:0]       lim, first_w, cnt_w, end_w;
  logic                rd_used, hit;
  logic [REF_BITS-1:0] rd_ref, ref_dn, ref_up;

  logic                out_valid_q;
  logic [2:0]          out_status_q;
  logic [11:0]         out_start_q;
  logic [REF_BITS-1:0] out_ref_q;
  logic [LW-1:0]       out_free_q, out_usable_q;

  assign lim     = (PW'(limit_q) < PW'(N_PAGES)) ? PW'(limit_q) : PW'(N_PAGES);
  assign first_w = PW'(first_page_i);
  assign cnt_w   = PW'(page_count_i);
  assign end_w   = first_w + cnt_w;

  assign rd_used = rdata_q[MW-1];
  assign rd_ref  = rdata_q[REF_BITS-1:0];
  assign ref_dn  = rd_ref - 1'b1;
  assign ref_up  = (rd_ref == '1) ? rd_ref : rd_ref + 1'b1;
  assign hit     = (op_q == OP_ALLOC) && !rd_used && (run_q + 1'b1 == cnt_q);

  assign mem_addr = ptr_q[AW-1:0];

  // Item start and per-page update (clearing pass, apply, take)
  always_comb begin
    mem_we     = 1'b0;
    mem_wdata  = {1'b1, REF_BITS'(1)};
    ptr_d      = ptr_q;
    run_d      = run_q;
    rs_d       = rs_q;
    found_d    = found_q;
    st_d       = st_q;
    refv_d     = refv_q;
    free_inc   = 1'b0;
    free_dec   = 1'b0;
    usable_inc = 1'b0;
    fail_d     = 1'b0;
    fail_st_d  = ST_OK;
    if (cmd_i.clear) begin
      mem_we = 1'b1;
      ptr_d  = ptr_q + 1'b1;
    end
    if (cmd_i.start) begin
      ptr_d   = (opcode_i == OP_ALLOC) ? PW'(1) : first_w;
      run_d   = '0;
      rs_d    = '0;
      found_d = 1'b0;
      st_d    = ST_OK;
      refv_d  = '0;
      case (opcode_i)
        OP_ADD_USABLE, OP_RESERVE: fail_d = 1'b0;
        OP_ALLOC: begin
          fail_d    = (page_count_i == '0);
          fail_st_d = ST_ZERO;
        end
        OP_FREE: begin
          fail_d    = (end_w > lim);
          fail_st_d = ST_BOUNDS;
        end
        OP_REF, OP_UNREF, OP_GETREF: begin
          fail_d    = (first_w >= lim);
          fail_st_d = ST_BOUNDS;
        end
        default: fail_d = 1'b1;
      endcase
    end
    if (cmd_i.apply) begin
      ptr_d = ptr_q + 1'b1;
      case (op_q)
        OP_ADD_USABLE: begin
          if (rd_used) begin
            mem_we     = 1'b1;
            mem_wdata  = '0;
            free_inc   = 1'b1;
            usable_inc = 1'b1;
          end
        end
        OP_RESERVE: begin
          if (!rd_used) begin
            mem_we   = 1'b1;
            free_dec = 1'b1;
          end
        end
        OP_ALLOC: begin
          if (rd_used) begin
            run_d = '0;
          end else begin
            if (run_q == '0) rs_d = ptr_q;
            run_d = run_q + 1'b1;
            if (hit) begin
              found_d = 1'b1;
              ptr_d   = (run_q == '0) ? ptr_q : rs_q;
            end
          end
        end
        OP_FREE, OP_UNREF: begin
          if (rd_ref == '0) begin
            st_d = ST_UNDER;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {rd_used && (ref_dn != '0), ref_dn};
            free_inc  = rd_used && (ref_dn == '0);
            // a range free reports no count
            if (op_q == OP_UNREF) refv_d = ref_dn;
          end
        end
        OP_REF: begin
          if (!rd_used) begin
            st_d = ST_REF_FREE;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, ref_up};
            refv_d    = ref_up;
          end
        end
        OP_GETREF: refv_d = rd_ref;
        default: ;
      endcase
    end
    if (cmd_i.take) begin
      mem_we   = 1'b1;
      free_dec = 1'b1;
      ptr_d    = ptr_q + 1'b1;
    end
  end

  always_comb begin
    free_d = free_q;
    if (free_inc && free_q < LW'(N_PAGES)) free_d = free_q + 1'b1;
    if (free_dec && free_q != '0)          free_d = free_q - 1'b1;
    usable_d = usable_q;
    if (usable_inc && usable_q < LW'(N_PAGES)) usable_d = usable_q + 1'b1;
  end

  // Loop termination for the latched item
  always_comb begin
    case (op_q)
      OP_ADD_USABLE, OP_RESERVE:   loop_done = (ptr_q >= end_q) || (ptr_q >= lim);
      OP_ALLOC:                    loop_done = (ptr_q >= lim);
      OP_FREE:                     loop_done = (ptr_q >= end_q);
      OP_REF, OP_UNREF, OP_GETREF: loop_done = visited_q;
      default:                     loop_done = 1'b1;
    endcase
  end

  assign sts_o.done      = loop_done;
  assign sts_o.clr_last  = (ptr_q == PW'(N_PAGES - 1));
  assign sts_o.fail      = fail_q;
  assign sts_o.hit       = hit;
  assign sts_o.take_last = (ptr_q + 1'b1 == rs_q + cnt_q);
  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd_i.rd) rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      ptr_q       <= '0;
      free_q      <= '0;
      usable_q    <= '0;
      fail_q      <= 1'b0;
      visited_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      ptr_q    <= ptr_d;
      free_q   <= free_d;
      usable_q <= usable_d;
      found_q  <= found_d;
      if (cmd_i.start) begin
        fail_q    <= fail_d;
        visited_q <= 1'b0;
      end else if (cmd_i.apply) begin
        visited_q <= 1'b1;
      end
      if (cmd_i.finish)     out_valid_q <= 1'b1;
      else if (rsp_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q  <= run_d;
    rs_q   <= rs_d;
    st_q   <= st_d;
    refv_q <= refv_d;
    if (cmd_i.start) begin
      op_q      <= opcode_i;
      end_q     <= end_w;
      cnt_q     <= cnt_w;
      fail_st_q <= fail_st_d;
    end
    if (cmd_i.finish) begin
      out_start_q  <= '0;
      out_ref_q    <= refv_q;
      out_free_q   <= free_q;
      out_usable_q <= usable_q;
      if (fail_q) begin
        out_status_q <= fail_st_q;
      end else if (op_q == OP_ALLOC && !found_q) begin
        out_status_q <= ST_NO_MEM;
      end else begin
        out_status_q <= st_q;
        if (op_q == OP_ALLOC) out_start_q <= 12'(rs_q);
      end
    end
  end

  assign rsp_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign alloc_page_o   = out_start_q;
  assign ref_value_o    = 16'(out_ref_q);
  assign free_total_o   = 13'(out_free_q);
  assign usable_total_o = 13'(out_usable_q);

endmodule

// ===== rtl/refcounted_page_allocator.sv =====
// Reference-counted page allocator: one result item per operation item.
// After reset a clearing pass sets every page used with count 1;
// no item is taken during it. Control state resets asynchronously on rst_ni low.
// Per item: each page visited takes one memory read and then one update;
// alloc scans from page 1 and then writes its run page by page.
// The single-port page memory sets the rate; a new item enters while a result waits.
module refcounted_page_allocator #(
  parameter int N_PAGES  = 4096,
  parameter int REF_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  rpa_req_if.sink     req_i,
  rpa_rsp_if.source   rsp_o
);
  import rpa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpa_datapath #(
    .N_PAGES  (N_PAGES),
    .REF_BITS (REF_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (req_i.opcode),
    .first_page_i   (req_i.first_page),
    .page_count_i   (req_i.page_count),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .alloc_page_o   (rsp_o.alloc_page),
    .ref_value_o    (rsp_o.ref_value),
    .free_total_o   (rsp_o.free_total),
    .usable_total_o (rsp_o.usable_total)
  );

endmodule
